[rtl/keyframe_position_interpolator_core_macros.svh]
// Assertion macros used by the keyframe interpolator checker.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef KEYFRAME_POSITION_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_POSITION_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KPI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpi check failed");

// next-cycle implication, disabled during reset
`define KPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpi check failed");

`endif

[rtl/kpi_pkg.sv]
// Shared constants and types of the keyframe position interpolator.
// Depends on nothing.
package kpi_pkg;
	localparam int MAX_FRAMES  = 1024;
	localparam int MAX_OBJECTS = 8;
	localparam int FRAC_BITS   = 16;
	localparam int FRAME_AW    = 10;
	localparam int OBJ_AW      = 3;
	localparam int REC_AW      = FRAME_AW + OBJ_AW;
	localparam int SCALE_W     = FRAC_BITS + 1;
	localparam int QCNT_W      = 5;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_FRAME_COUNT  = 1'b0,
		REG_OBJECT_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_SCAN_RD  = 11'b000_0000_0010,
		S_SCAN_CMP = 11'b000_0000_0100,
		S_T0_RD    = 11'b000_0000_1000,
		S_T1_RD    = 11'b000_0001_0000,
		S_T_CAP    = 11'b000_0010_0000,
		S_DIV      = 11'b000_0100_0000,
		S_OBJ_RD0  = 11'b000_1000_0000,
		S_OBJ_RD1  = 11'b001_0000_0000,
		S_OBJ_MUL  = 11'b010_0000_0000,
		S_OBJ_ADD  = 11'b100_0000_0000
	} state_t;
endpackage

[rtl/kpi_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module kpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[rtl/kpi_div.sv]
// Bit-serial restoring divider for the interpolation scale, one bit a cycle.
// Depends on kpi_pkg; the numerator must not exceed the denominator.
module kpi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 num,
	input  logic [31:0]                 den,
	output logic                        done,
	output logic [kpi_pkg::SCALE_W-1:0] quo
);
	logic                       run_q;
	logic [kpi_pkg::QCNT_W-1:0] cnt_q;
	logic [32:0]                rem_q;
	logic [31:0]                den_q;
	logic                       fits;
	logic [32:0]                rem_next;

	assign fits     = rem_q >= {1'b0, den_q};
	assign rem_next = fits ? (rem_q - {1'b0, den_q}) : rem_q;

	// control: count quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= kpi_pkg::QCNT_W'(kpi_pkg::SCALE_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// datapath: shift remainder, collect one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo   <= '0;
		end else if (run_q) begin
			rem_q <= {rem_next[31:0], 1'b0};
			quo   <= {quo[kpi_pkg::SCALE_W-2:0], fits};
		end
	end
endmodule

[rtl/keyframe_position_interpolator_core.sv]
// Keyframe position interpolator: a load writes one keyframe record and gives no result.
// Query: the cursor scans forward frame by frame, the frame times are fetched, and
// the bit-serial divider forms the scale when the span is positive and the cursor
// is not on the last frame; then one result comes out for each object.
// Reset clears cursor and registers (1 frame, 1 object); memories are not cleared.
// Depends on kpi_pkg, kpi_ram and kpi_div.
module keyframe_position_interpolator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [9:0]         frame_index,
	input  logic [2:0]         object_index,
	input  logic [31:0]        time_stamp,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] heading,
	input  logic signed [31:0] pitch,
	input  logic signed [31:0] roll,
	output logic               done,
	output logic [2:0]         out_object,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_heading,
	output logic signed [31:0] out_pitch,
	output logic signed [31:0] out_roll,
	output logic               at_end,
	output logic               last
);
	kpi_pkg::state_t state_q;
	logic [10:0] frame_count_q;
	logic [3:0]  object_count_q;
	logic [kpi_pkg::FRAME_AW-1:0] cur_q;
	logic [kpi_pkg::OBJ_AW-1:0]   k_q;
	logic [31:0] t_q;
	logic [31:0] t0_q;
	logic [kpi_pkg::SCALE_W-1:0] scale_q;
	logic        at_end_q;
	logic [95:0] pos_a_q;
	logic [95:0] ang_q;
	logic signed [50:0] prod_s1 [3];

	logic [10:0] n_frames;
	logic [3:0]  n_objs;
	logic [kpi_pkg::FRAME_AW-1:0] cur_next;
	logic [10:0] cur_plus;
	logic        load_go;
	logic        query_go;

	logic                         ft_we;
	logic [kpi_pkg::FRAME_AW-1:0] ft_addr;
	logic [31:0]                  ft_rdata;
	logic                         rec_we;
	logic [kpi_pkg::REC_AW-1:0]   rec_addr;
	logic [95:0]                  pos_rdata;
	logic [95:0]                  ang_rdata;

	logic        div_start;
	logic [31:0] div_num;
	logic [31:0] div_den;
	logic        div_done;
	logic [kpi_pkg::SCALE_W-1:0] div_quo;
	logic [31:0] span;
	logic [31:0] elapsed;

	// clamp registers to their legal ranges
	always_comb begin
		priority if (frame_count_q == '0) begin
			n_frames = 11'd1;
		end else if (frame_count_q > 11'(kpi_pkg::MAX_FRAMES)) begin
			n_frames = 11'(kpi_pkg::MAX_FRAMES);
		end else begin
			n_frames = frame_count_q;
		end
		priority if (object_count_q == '0) begin
			n_objs = 4'd1;
		end else if (object_count_q > 4'(kpi_pkg::MAX_OBJECTS)) begin
			n_objs = 4'(kpi_pkg::MAX_OBJECTS);
		end else begin
			n_objs = object_count_q;
		end
	end

	assign busy     = (state_q != kpi_pkg::S_IDLE);
	assign load_go  = start && !busy && (operation == kpi_pkg::OP_LOAD);
	assign query_go = start && !busy && (operation == kpi_pkg::OP_QUERY);
	assign cur_next = cur_q + 1'b1;
	assign cur_plus = {1'b0, cur_q} + 11'd1;

	// pull the stored cursor back inside the frames in use
	logic [kpi_pkg::FRAME_AW-1:0] cur_clamped;
	always_comb begin
		if ({1'b0, cur_q} >= n_frames) begin
			cur_clamped = kpi_pkg::FRAME_AW'(n_frames - 11'd1);
		end else begin
			cur_clamped = cur_q;
		end
	end

	// frame time memory address
	always_comb begin
		ft_we = load_go;
		unique case (state_q)
			kpi_pkg::S_SCAN_RD: ft_addr = cur_next;
			kpi_pkg::S_T0_RD:   ft_addr = cur_q;
			kpi_pkg::S_T1_RD:   ft_addr = cur_next;
			default:            ft_addr = frame_index;
		endcase
	end

	// record memory address: current or next frame of object k, else the load address
	always_comb begin
		rec_we = load_go;
		unique case (state_q)
			kpi_pkg::S_OBJ_RD0: rec_addr = {cur_q, k_q};
			kpi_pkg::S_OBJ_RD1: rec_addr = {cur_next, k_q};
			default:            rec_addr = {frame_index, object_index};
		endcase
	end

	kpi_ram #(.WIDTH(32), .DEPTH(kpi_pkg::MAX_FRAMES)) u_frame_times (
		.clk(clk), .we(ft_we), .addr(ft_addr), .wdata(time_stamp), .rdata(ft_rdata)
	);

	kpi_ram #(.WIDTH(96), .DEPTH(kpi_pkg::MAX_FRAMES * kpi_pkg::MAX_OBJECTS)) u_positions (
		.clk(clk), .we(rec_we), .addr(rec_addr),
		.wdata({pos_z, pos_y, pos_x}), .rdata(pos_rdata)
	);

	kpi_ram #(.WIDTH(96), .DEPTH(kpi_pkg::MAX_FRAMES * kpi_pkg::MAX_OBJECTS)) u_angles (
		.clk(clk), .we(rec_we), .addr(rec_addr),
		.wdata({roll, pitch, heading}), .rdata(ang_rdata)
	);

	// scale operands: clamp the elapsed time into [0, span]
	always_comb begin
		span    = ft_rdata - t0_q;
		elapsed = (t_q > t0_q) ? (t_q - t0_q) : 32'd0;
		div_num = (elapsed > span) ? span : elapsed;
		div_den = span;
		div_start = (state_q == kpi_pkg::S_T_CAP) && (ft_rdata > t0_q);
	end

	kpi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= 11'd1;
			object_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (kpi_pkg::reg_idx_t'(cfg_index))
				kpi_pkg::REG_FRAME_COUNT:  frame_count_q  <= cfg_data;
				kpi_pkg::REG_OBJECT_COUNT: object_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer: scan, divide, then walk the objects
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kpi_pkg::S_IDLE;
			cur_q    <= '0;
			k_q      <= '0;
			at_end_q <= 1'b0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				kpi_pkg::S_IDLE: begin
					if (load_go) begin
						cur_q <= '0;
					end else if (query_go) begin
						cur_q   <= cur_clamped;
						state_q <= kpi_pkg::S_SCAN_RD;
					end
				end
				kpi_pkg::S_SCAN_RD: begin
					if (cur_plus < n_frames) begin
						state_q <= kpi_pkg::S_SCAN_CMP;
					end else begin
						state_q <= kpi_pkg::S_T0_RD;
					end
				end
				kpi_pkg::S_SCAN_CMP: begin
					if (ft_rdata <= t_q) begin
						cur_q   <= cur_next;
						state_q <= kpi_pkg::S_SCAN_RD;
					end else begin
						state_q <= kpi_pkg::S_T0_RD;
					end
				end
				kpi_pkg::S_T0_RD: begin
					k_q <= '0;
					if (cur_plus >= n_frames) begin
						at_end_q <= 1'b1;
						state_q  <= kpi_pkg::S_OBJ_RD0;
					end else begin
						at_end_q <= 1'b0;
						state_q  <= kpi_pkg::S_T1_RD;
					end
				end
				kpi_pkg::S_T1_RD: state_q <= kpi_pkg::S_T_CAP;
				kpi_pkg::S_T_CAP: begin
					if (div_start) begin
						state_q <= kpi_pkg::S_DIV;
					end else begin
						state_q <= kpi_pkg::S_OBJ_RD0;
					end
				end
				kpi_pkg::S_DIV: begin
					if (div_done) begin
						state_q <= kpi_pkg::S_OBJ_RD0;
					end
				end
				kpi_pkg::S_OBJ_RD0: state_q <= kpi_pkg::S_OBJ_RD1;
				kpi_pkg::S_OBJ_RD1: state_q <= kpi_pkg::S_OBJ_MUL;
				kpi_pkg::S_OBJ_MUL: state_q <= kpi_pkg::S_OBJ_ADD;
				kpi_pkg::S_OBJ_ADD: begin
					done <= 1'b1;
					k_q  <= k_q + 1'b1;
					if ({1'b0, k_q} == n_objs - 4'd1) begin
						state_q <= kpi_pkg::S_IDLE;
					end else begin
						state_q <= kpi_pkg::S_OBJ_RD0;
					end
				end
				default: state_q <= kpi_pkg::S_IDLE;
			endcase
		end
	end

	// datapath registers: query time, start frame time, scale, start records
	always_ff @(posedge clk) begin
		if (query_go) begin
			t_q <= time_stamp;
		end
		if (state_q == kpi_pkg::S_T1_RD) begin
			t0_q <= ft_rdata;
		end
		if ((state_q == kpi_pkg::S_T0_RD) || (state_q == kpi_pkg::S_T_CAP)) begin
			scale_q <= '0;
		end else if ((state_q == kpi_pkg::S_DIV) && div_done) begin
			scale_q <= div_quo;
		end
		if (state_q == kpi_pkg::S_OBJ_RD1) begin
			pos_a_q <= pos_rdata;
			ang_q   <= ang_rdata;
		end
	end

	// multiply each coordinate difference by the scale
	logic signed [32:0] diff [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (at_end_q) begin
				diff[j] = '0;
			end else begin
				diff[j] = {pos_rdata[32*j+31], pos_rdata[32*j +: 32]}
					- {pos_a_q[32*j+31], pos_a_q[32*j +: 32]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kpi_pkg::S_OBJ_MUL) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[j] <= 51'(diff[j]) * 51'($signed({1'b0, scale_q}));
			end
		end
	end

	// round, add to the start position, and register the result
	logic signed [50:0] rnd [3];
	logic [31:0] pos_out [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rnd[j] = prod_s1[j] + 51'sd32768;
			pos_out[j] = pos_a_q[32*j +: 32] + 32'(rnd[j] >>> kpi_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kpi_pkg::S_OBJ_ADD) begin
			out_object  <= k_q;
			out_x       <= pos_out[0];
			out_y       <= pos_out[1];
			out_z       <= pos_out[2];
			out_heading <= ang_q[31:0];
			out_pitch   <= ang_q[63:32];
			out_roll    <= ang_q[95:64];
			at_end      <= at_end_q;
			last        <= ({1'b0, k_q} == n_objs - 4'd1);
		end
	end
endmodule

[rtl/kpi_checker.sv]
// Port-level checks of the keyframe interpolator, bound to the top level.
// Depends on keyframe_position_interpolator_core_macros.svh.
`include "keyframe_position_interpolator_core_macros.svh"
module kpi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done,
	input logic last
);
	// the final object ends the query; nothing follows directly
	`KPI_ASSERT_NEXT(a_last_then_quiet, done && last, !done)
	// more objects still owed keep the block busy
	`KPI_ASSERT_NOW(a_more_keeps_busy, done && !last, busy)
	// a load request yields no result
	`KPI_ASSERT_NEXT(a_load_silent, start && !busy && !operation, !done && !busy)
endmodule

bind keyframe_position_interpolator_core kpi_checker u_kpi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.operation(operation), .done(done), .last(last)
);

[verif/tb_keyframe_position_interpolator_core.sv]
// Self-checking testbench for keyframe_position_interpolator_core: loads keyframe
// tables, issues time queries and checks every interpolated pose against a local predictor.
// Depends on kpi_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_keyframe_position_interpolator_core;
	import kpi_pkg::*;

	typedef struct {
		logic [2:0]  obj;
		logic [31:0] x, y, z, hd, pt, rl;
		logic        end_flag, last_flag;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic operation = 1'b0;
	logic [9:0] frame_index = '0;
	logic [2:0] object_index = '0;
	logic [31:0] time_stamp = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] heading = '0, pitch = '0, roll = '0;
	logic done;
	logic [2:0] out_object;
	logic signed [31:0] out_x, out_y, out_z, out_heading, out_pitch, out_roll;
	logic at_end, last;

	keyframe_position_interpolator_core dut (.*);

	always #2 clk = ~clk;

	// local copy of the keyframe store and registers
	logic [31:0] key_time [MAX_FRAMES];
	logic [31:0] key_pos [MAX_FRAMES*MAX_OBJECTS][3];
	logic [31:0] key_ang [MAX_FRAMES*MAX_OBJECTS][3];
	bit rec_loaded [MAX_FRAMES*MAX_OBJECTS];
	int unsigned cursor_pos;
	logic [10:0] reg_frames;
	logic [3:0] reg_objects;

	pose_t pending_poses [$];
	int errors, items, loads, queries, poses, end_poses, idle_pct, quiet_cycles;

	function automatic int unsigned eff_frames();
		if (reg_frames == 0) return 1;
		if (reg_frames > MAX_FRAMES) return MAX_FRAMES;
		return reg_frames;
	endfunction

	function automatic int unsigned eff_objects();
		if (reg_objects == 0) return 1;
		if (reg_objects > MAX_OBJECTS) return MAX_OBJECTS;
		return reg_objects;
	endfunction

	// position between a and b, rounded to nearest with ties up
	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint scale);
		longint a0, diff, delta;
		a0 = longint'(signed'(a));
		diff = longint'(signed'(b)) - a0;
		delta = (diff * scale + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		return 32'(a0 + delta);
	endfunction

	// advance the cursor and queue one pose per object
	task automatic predict_poses(logic [31:0] t);
		int unsigned n, objs, cur, e;
		longint unsigned num, den;
		longint scale;
		bit fin;
		pose_t p;
		n = eff_frames();
		objs = eff_objects();
		cur = cursor_pos;
		scale = 0;
		if (cur >= n) cur = n - 1;
		while (cur + 1 < n && key_time[cur+1] <= t) cur++;
		cursor_pos = cur;
		fin = (cur + 1 >= n);
		if (!fin && key_time[cur+1] > key_time[cur]) begin
			den = key_time[cur+1] - key_time[cur];
			num = (t > key_time[cur]) ? t - key_time[cur] : 0;
			if (num > den) num = den;
			scale = longint'((num << FRAC_BITS) / den);
		end
		for (int k = 0; k < objs; k++) begin
			e = cur * MAX_OBJECTS + k;
			p.obj = 3'(k);
			p.x = fin ? key_pos[e][0] : blend(key_pos[e][0], key_pos[e+MAX_OBJECTS][0], scale);
			p.y = fin ? key_pos[e][1] : blend(key_pos[e][1], key_pos[e+MAX_OBJECTS][1], scale);
			p.z = fin ? key_pos[e][2] : blend(key_pos[e][2], key_pos[e+MAX_OBJECTS][2], scale);
			p.hd = key_ang[e][0];
			p.pt = key_ang[e][1];
			p.rl = key_ang[e][2];
			p.end_flag = fin;
			p.last_flag = (k + 1 == objs);
			pending_poses.push_back(p);
		end
	endtask

	// drive one request and hold it until the core takes it
	task automatic send_request(op_t op, int unsigned fi, int unsigned oi, logic [31:0] t,
			logic [31:0] vals [6]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		frame_index <= 10'(fi);
		object_index <= 3'(oi);
		time_stamp <= t;
		pos_x <= vals[0]; pos_y <= vals[1]; pos_z <= vals[2];
		heading <= vals[3]; pitch <= vals[4]; roll <= vals[5];
		@(posedge clk);
		while (busy) @(posedge clk);
		quiet_cycles = 0;
		items++;
		if (op == OP_LOAD) begin
			loads++;
			cursor_pos = 0;
			key_time[fi] = t;
			for (int j = 0; j < 3; j++) begin
				key_pos[fi*MAX_OBJECTS+oi][j] = vals[j];
				key_ang[fi*MAX_OBJECTS+oi][j] = vals[3+j];
			end
			rec_loaded[fi*MAX_OBJECTS+oi] = 1'b1;
		end else begin
			queries++;
			predict_poses(t);
		end
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_record(int unsigned fi, int unsigned oi, logic [31:0] t);
		logic [31:0] vals [6];
		foreach (vals[j]) vals[j] = rand_word();
		send_request(OP_LOAD, fi, oi, t, vals);
	endtask

	task automatic query_at(logic [31:0] t);
		logic [31:0] vals [6];
		foreach (vals[j]) vals[j] = $urandom;
		send_request(OP_QUERY, $urandom_range(1023), $urandom_range(7), t, vals);
	endtask

	// drain all results, let the core settle, then write a register
	task automatic write_reg(reg_idx_t idx, logic [10:0] value);
		start <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_COUNT) reg_frames = value;
		else reg_objects = 4'(value);
	endtask

	// load a table with rising frame times; some steps are zero
	task automatic load_table(int unsigned n, int unsigned objs, logic [31:0] base,
			logic [31:0] step_max);
		logic [31:0] t;
		t = base;
		for (int f = 0; f < n; f++) begin
			for (int o = 0; o < objs; o++) load_record(f, o, t);
			t += ($urandom_range(5) == 0) ? 0 : $urandom_range(step_max, 1);
		end
	endtask

	// fill any record that a query could read but was never loaded
	task automatic fill_missing();
		for (int f = 0; f < eff_frames(); f++)
			for (int o = 0; o < eff_objects(); o++)
				if (!rec_loaded[f*MAX_OBJECTS+o]) load_record(f, o, $urandom);
	endtask

	task automatic test_directed();
		logic [31:0] vals [6];
		write_reg(REG_FRAME_COUNT, 11'd0);
		write_reg(REG_OBJECT_COUNT, 11'd15);
		// frame 1 earlier than frame 0 gives zero scale
		vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		send_request(OP_LOAD, 0, 0, 32'd5000, vals);
		vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3};
		send_request(OP_LOAD, 1, 0, 32'd2000, vals);
		send_request(OP_LOAD, 2, 0, 32'hFFFF_FFFF, vals);
		for (int o = 1; o < MAX_OBJECTS; o++) begin
			load_record(0, o, 32'd5000);
			load_record(1, o, 32'd2000);
			load_record(2, o, 32'hFFFF_FFFF);
		end
		query_at(32'd0);
		write_reg(REG_FRAME_COUNT, 11'd3);
		query_at(32'd1000);
		query_at(32'd0);
		query_at(32'd3000);
		query_at(32'hFFFF_FFFE);
		query_at(32'hFFFF_FFFF);
		write_reg(REG_OBJECT_COUNT, 11'd0);
		query_at(32'hFFFF_FFFF);
	endtask

	// shrink the frame count under a cursor that sits past it
	task automatic test_cursor_clamp();
		write_reg(REG_FRAME_COUNT, 11'd6);
		write_reg(REG_OBJECT_COUNT, 11'd2);
		load_table(6, 2, 32'd100, 32'h0001_0000);
		query_at(32'hFFFF_FFFF);
		write_reg(REG_FRAME_COUNT, 11'd3);
		query_at(32'd0);
		query_at(32'hFFFF_FFFF);
	endtask

	// frame count written above its range over a short table
	task automatic test_full_store();
		write_reg(REG_FRAME_COUNT, 11'd2047);
		write_reg(REG_OBJECT_COUNT, 11'd1);
		load_table(12, 1, 32'd0, 32'h0040_0000);
		// a frame at the latest time stops the scan inside the loaded part
		load_record(12, 0, 32'hFFFF_FFFF);
		query_at(key_time[6] + 32'd7);
		query_at(32'hFFFF_FFFE);
		write_reg(REG_FRAME_COUNT, 11'd1024);
		query_at(key_time[11]);
	endtask

	task automatic test_random();
		int unsigned n, objs, target;
		logic [31:0] t, span;
		target = items + 380;
		while (items < target) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 2);
			objs = $urandom_range(MAX_OBJECTS, 1);
			write_reg(REG_FRAME_COUNT, ($urandom_range(7) == 0) ? 11'd0 : 11'(n));
			write_reg(REG_OBJECT_COUNT, ($urandom_range(7) == 0) ? 11'($urandom_range(15, 9))
				: 11'(objs));
			n = eff_frames();
			objs = eff_objects();
			span = $urandom_range(3) == 0 ? 32'h0FFF_FFFF : 32'h0002_0000;
			if ($urandom_range(3) != 0) load_table(n, objs, $urandom, span);
			fill_missing();
			t = key_time[0] - 32'($urandom_range(50));
			repeat ($urandom_range(20, 6)) begin
				if ($urandom_range(9) == 0) begin
					// stray load into the used part of the table
					load_record($urandom_range(n - 1), $urandom_range(objs - 1), $urandom);
				end else if ($urandom_range(9) == 0) begin
					query_at($urandom);
				end else begin
					t += $urandom_range(span);
					query_at(t);
				end
			end
			if ($urandom_range(3) == 0) idle_pct = (idle_pct == 0) ? 20 : 0;
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			quiet_cycles = 0;
			if (pending_poses.size() == 0) begin
				$error("unexpected result for object %0d", out_object);
				errors++;
			end else begin
				pose_t p;
				p = pending_poses.pop_front();
				poses++;
				if (at_end) end_poses++;
				if (out_object !== p.obj) begin
					$error("out_object exp %0d got %0d", p.obj, out_object); errors++;
				end
				if (out_x !== p.x) begin
					$error("out_x exp %h got %h", p.x, out_x); errors++;
				end
				if (out_y !== p.y) begin
					$error("out_y exp %h got %h", p.y, out_y); errors++;
				end
				if (out_z !== p.z) begin
					$error("out_z exp %h got %h", p.z, out_z); errors++;
				end
				if (out_heading !== p.hd) begin
					$error("out_heading exp %h got %h", p.hd, out_heading); errors++;
				end
				if (out_pitch !== p.pt) begin
					$error("out_pitch exp %h got %h", p.pt, out_pitch); errors++;
				end
				if (out_roll !== p.rl) begin
					$error("out_roll exp %h got %h", p.rl, out_roll); errors++;
				end
				if (at_end !== p.end_flag) begin
					$error("at_end exp %0b got %0b", p.end_flag, at_end); errors++;
				end
				if (last !== p.last_flag) begin
					$error("last exp %0b got %0b", p.last_flag, last); errors++;
				end
			end
		end
	end

	// abort when nothing moves for too long
	always @(posedge clk) begin
		quiet_cycles++;
		if (quiet_cycles > 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		cursor_pos = 0;
		reg_frames = 11'd1;
		reg_objects = 4'd1;
		idle_pct = 20;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_cursor_clamp();
		idle_pct = 0;
		test_full_store();
		idle_pct = 20;
		test_random();
		start <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d requests: %0d loads, %0d queries, %0d poses (%0d at end)",
			items, loads, queries, poses, end_poses);
		if (errors == 0 && pending_poses.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
